/* rtl/mck_pkg.sv */
package mck_pkg;

    localparam int MAX_ELEMENTS = 8;
    localparam int CODE_DEPTH   = 53;
    localparam int CODE_AW      = $clog2(CODE_DEPTH);
    localparam int BITS_W       = 8;
    localparam int COUNT_W      = 4;
    localparam int CODE_W       = BITS_W + COUNT_W;
    localparam int UNIT_W       = 12;
    localparam int MULT_W       = 4;
    localparam int DUR_W        = 16;
    localparam int CHAR_W       = 8;
    localparam int CFG_IDX_W    = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_UNITS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_UNITS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP_UNITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP_UNITS = 3'd4;

    // Code words: element bits in [15:8] (first element in the MSB, 1 is a dit),
    // element count in [3:0].
    localparam logic [15:0] CODE_ROM [CODE_DEPTH] = '{
        16'h8002, 16'h7004, 16'h5004, 16'h6003, 16'h8001, 16'hD004, 16'h2003,
        16'hF004, 16'hC002, 16'h8004, 16'h4003, 16'hB004, 16'h0002, 16'h4002,
        16'h0003, 16'h9004, 16'h2004, 16'hA003, 16'hE003, 16'h0001, 16'hC003,
        16'hE004, 16'h8003, 16'h6004, 16'h4004, 16'h3004,
        16'h0005, 16'h8005, 16'hC005, 16'hE005, 16'hF005, 16'hF805, 16'h7805,
        16'h3805, 16'h1805, 16'h0805,
        16'h5006, 16'hB406, 16'hB805, 16'h8406, 16'h4805, 16'h4806, 16'hA805,
        16'h3006, 16'h7806, 16'hA806, 16'h6805, 16'h1C06, 16'h5406, 16'h7005,
        16'hCC06, 16'h9406, 16'hC806
    };

    typedef struct packed {
        logic [UNIT_W-1:0] unit_ticks;
        logic [MULT_W-1:0] dot_units;
        logic [MULT_W-1:0] dash_units;
        logic [MULT_W-1:0] char_gap_units;
        logic [MULT_W-1:0] word_gap_units;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [CODE_AW-1:0] idx;
    } lookup_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_TONE,
        ST_SPACE,
        ST_CGAP,
        ST_WGAP
    } seq_state_t;

    // Maps an ASCII code to its place in the code table.
    function automatic lookup_t mck_lookup(input logic [CHAR_W-1:0] c);
        lookup_t r;
        r.valid = 1'b1;
        r.idx   = '0;
        if (c >= 8'd97 && c <= 8'd122) begin
            r.idx = CODE_AW'(c - 8'd97);
        end else if (c >= 8'd65 && c <= 8'd90) begin
            r.idx = CODE_AW'(c - 8'd65);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r.idx = CODE_AW'(c - 8'd22);
        end else begin
            unique case (c)
                8'd33:   r.idx = CODE_AW'(36);
                8'd34:   r.idx = CODE_AW'(37);
                8'd38:   r.idx = CODE_AW'(38);
                8'd39:   r.idx = CODE_AW'(39);
                8'd40:   r.idx = CODE_AW'(40);
                8'd41:   r.idx = CODE_AW'(41);
                8'd43:   r.idx = CODE_AW'(42);
                8'd44:   r.idx = CODE_AW'(43);
                8'd45:   r.idx = CODE_AW'(44);
                8'd46:   r.idx = CODE_AW'(45);
                8'd47:   r.idx = CODE_AW'(46);
                8'd58:   r.idx = CODE_AW'(47);
                8'd59:   r.idx = CODE_AW'(48);
                8'd61:   r.idx = CODE_AW'(49);
                8'd63:   r.idx = CODE_AW'(50);
                8'd64:   r.idx = CODE_AW'(51);
                8'd95:   r.idx = CODE_AW'(52);
                default: r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/morse_character_keyer.sv */
// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   tdata: char_code; tlast: end_of_text
// m_        out        m_tvalid/m_tready   tdata: duration_ticks; tuser: key_down;
//                                          tlast: last
// cfg_      in         cfg_valid/cfg_ready cfg_index: register; cfg_data: value
//
// An item is taken in one cycle and its code word is read from the code memory in the
// next; then one interval per cycle is loaded into the output register unless the output
// stalls. Each item holds the sequencer until its last interval is loaded; the next item
// can be taken once the sequencer is back in idle. After reset the memory is filled from
// the built-in table, with no item taken meanwhile. A stalled output holds the sequencer
// in place; nothing is lost.
module morse_character_keyer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mck_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] char_code
    input  logic                               s_tlast,   // end_of_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mck_pkg::DUR_W-1:0]          m_tdata,   // [15:0] duration_ticks
    output logic                               m_tuser,   // [0] key_down
    output logic                               m_tlast,   // last
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mck_pkg::UNIT_W-1:0]         cfg_data
);

    import mck_pkg::*;

    // Configuration registers, written whenever the port offers a write.
    cfg_t                cfg_reg;
    // Fill pass that loads the code table into the memory after reset.
    logic                fill_busy_reg;
    logic [CODE_AW-1:0]  fill_cnt_reg;
    logic [15:0]         fill_word;
    logic [CODE_W-1:0]   fill_data;

    logic [CODE_AW-1:0]  rd_addr;
    logic [CODE_W-1:0]   rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_ticks     <= UNIT_W'(100);
            cfg_reg.dot_units      <= MULT_W'(1);
            cfg_reg.dash_units     <= MULT_W'(3);
            cfg_reg.char_gap_units <= MULT_W'(3);
            cfg_reg.word_gap_units <= MULT_W'(7);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_UNIT_TICKS:     cfg_reg.unit_ticks     <= cfg_data;
                REG_DOT_UNITS:      cfg_reg.dot_units      <= cfg_data[MULT_W-1:0];
                REG_DASH_UNITS:     cfg_reg.dash_units     <= cfg_data[MULT_W-1:0];
                REG_CHAR_GAP_UNITS: cfg_reg.char_gap_units <= cfg_data[MULT_W-1:0];
                REG_WORD_GAP_UNITS: cfg_reg.word_gap_units <= cfg_data[MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The memory keeps only the element bits and the count of each code word.
    assign fill_word = CODE_ROM[fill_cnt_reg];
    assign fill_data = {fill_word[15:8], fill_word[COUNT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
        end else if (fill_busy_reg) begin
            if (fill_cnt_reg == CODE_AW'(CODE_DEPTH - 1)) begin
                fill_busy_reg <= 1'b0;
            end else begin
                fill_cnt_reg <= fill_cnt_reg + CODE_AW'(1);
            end
        end
    end

    mck_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CODE_DEPTH)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (fill_busy_reg),
        .waddr (fill_cnt_reg),
        .wdata (fill_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mck_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .fill_busy      (fill_busy_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .char_code      (s_tdata),
        .end_of_text    (s_tlast),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .key_down       (m_tuser),
        .duration_ticks (m_tdata),
        .last           (m_tlast)
    );

endmodule

/* rtl/mck_ram.sv */
module mck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mck_seq.sv */
module mck_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mck_pkg::cfg_t                  cfg,
    input  logic                           fill_busy,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mck_pkg::CHAR_W-1:0]     char_code,
    input  logic                           end_of_text,
    output logic [mck_pkg::CODE_AW-1:0]    rd_addr,
    input  logic [mck_pkg::CODE_W-1:0]     rd_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           key_down,
    output logic [mck_pkg::DUR_W-1:0]      duration_ticks,
    output logic                           last
);

    import mck_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                eot_reg, eot_next;
    logic                code_ok_reg, code_ok_next;

    logic                out_valid_reg;
    logic                key_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic                last_reg;

    lookup_t             lut;
    logic [COUNT_W-1:0]  count_raw;
    logic [COUNT_W-1:0]  count_clamped;
    logic                advance;
    logic                emit;
    logic                emit_key;
    logic                emit_last;
    logic [MULT_W-1:0]   emit_units;
    logic [DUR_W-1:0]    product;

    assign lut     = mck_lookup(char_code);
    assign rd_addr = lut.idx;

    assign count_raw     = rd_data[COUNT_W-1:0];
    assign count_clamped = (count_raw > COUNT_W'(MAX_ELEMENTS)) ?
                           COUNT_W'(MAX_ELEMENTS) : count_raw;

    // The output register moves on when it is empty or being taken.
    assign advance = !out_valid_reg || out_ready;

    always_comb begin
        in_ready   = (state_reg == ST_IDLE) && !fill_busy;
        emit       = 1'b0;
        emit_key   = 1'b0;
        emit_last  = 1'b0;
        emit_units = '0;
        unique case (state_reg)
            ST_IDLE, ST_LOOK: begin
            end
            ST_TONE: begin
                emit       = 1'b1;
                emit_key   = 1'b1;
                emit_units = bits_reg[BITS_W-1] ? cfg.dot_units : cfg.dash_units;
            end
            ST_SPACE: begin
                emit       = 1'b1;
                emit_units = MULT_W'(1);
            end
            ST_CGAP: begin
                emit       = 1'b1;
                emit_units = cfg.char_gap_units;
                emit_last  = !eot_reg;
            end
            ST_WGAP: begin
                emit       = 1'b1;
                emit_units = cfg.word_gap_units;
                emit_last  = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        bits_next    = bits_reg;
        count_next   = count_reg;
        eot_next     = eot_reg;
        code_ok_next = code_ok_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    state_next   = ST_LOOK;
                    eot_next     = end_of_text;
                    code_ok_next = lut.valid;
                end
            end
            ST_LOOK: begin
                bits_next  = rd_data[CODE_W-1:COUNT_W];
                count_next = count_clamped;
                if (code_ok_reg && (count_clamped != '0)) begin
                    state_next = ST_TONE;
                end else begin
                    state_next = ST_CGAP;
                end
            end
            ST_TONE: begin
                if (advance) begin
                    state_next = ST_SPACE;
                end
            end
            ST_SPACE: begin
                if (advance) begin
                    bits_next  = {bits_reg[BITS_W-2:0], 1'b0};
                    count_next = count_reg - COUNT_W'(1);
                    state_next = (count_reg == COUNT_W'(1)) ? ST_CGAP : ST_TONE;
                end
            end
            ST_CGAP: begin
                if (advance) begin
                    state_next = eot_reg ? ST_WGAP : ST_IDLE;
                end
            end
            ST_WGAP: begin
                if (advance) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign product = DUR_W'(cfg.unit_ticks) * DUR_W'(emit_units);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                out_valid_reg <= emit;
            end
        end
        bits_reg    <= bits_next;
        count_reg   <= count_next;
        eot_reg     <= eot_next;
        code_ok_reg <= code_ok_next;
        if (advance && emit) begin
            key_reg  <= emit_key;
            dur_reg  <= product;
            last_reg <= emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_down       = key_reg;
    assign duration_ticks = dur_reg;
    assign last           = last_reg;

endmodule
